// ===== rtl/json_string_member_extract_unit_assert.svh =====
// ----------------------------------------------------------------------------
// JSON string member extract unit: assertion macros
// Shared property forms for the concurrent checks of the extract unit.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_MEMBER_EXTRACT_UNIT_ASSERT_SVH
`define JSON_STRING_MEMBER_EXTRACT_UNIT_ASSERT_SVH

// Same-cycle implication, checked while reset is low.
`define JSME_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while reset is low.
`define JSME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/jsme_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string member extract package
// Types, codes and character constants of the JSON string member extractor.
// ----------------------------------------------------------------------------
package jsme_pkg;

   localparam int MAX_KEY_BYTES = 32;
   localparam int KEY_REGS      = 4;
   localparam int OUT_DEPTH     = 4;

   // Scanner phases.
   typedef enum logic [2:0] {
      PH_SEARCH     = 3'd0,
      PH_MATCH      = 3'd1,
      PH_AFTERKEY   = 3'd3,
      PH_AFTERCOLON = 3'd4,
      PH_VALUE      = 3'd5,
      PH_ESCAPE     = 3'd6,
      PH_HEXSKIP    = 3'd7
   } phase_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_KEY_LENGTH = 3'd0,
      REG_KEY_0_7    = 3'd1,
      REG_KEY_8_15   = 3'd2,
      REG_KEY_16_23  = 3'd3,
      REG_KEY_24_31  = 3'd4,
      REG_MAX_CHARS  = 3'd5
   } reg_index_type;

   // Status codes of the final transaction.
   localparam logic [1:0] ST_FOUND      = 2'd0;
   localparam logic [1:0] ST_EMPTY      = 2'd1;
   localparam logic [1:0] ST_MISSING    = 2'd2;
   localparam logic [1:0] ST_NOT_STRING = 2'd3;

   // Characters.
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_QUESTION  = 8'h3F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_LOW_N     = 8'h6E;
   localparam logic [7:0] CH_LOW_R     = 8'h72;
   localparam logic [7:0] CH_LOW_T     = 8'h74;
   localparam logic [7:0] CH_LOW_B     = 8'h62;
   localparam logic [7:0] CH_LOW_F     = 8'h66;
   localparam logic [7:0] CH_LOW_U     = 8'h75;

   // One result transaction.
   typedef struct packed {
      logic [7:0] value_char;
      logic       is_final;
      logic [1:0] status;
   } rsp_type;

   // Outcome of comparing one byte against the key.
   typedef struct packed {
      phase_type  phase;
      logic [5:0] pos;
   } cand_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
   endfunction

endpackage

// ===== rtl/json_string_member_extract_unit.sv =====
// ----------------------------------------------------------------------------
// JSON string member extract unit
// Finds the first member whose key equals the configured key in a JSON byte
// stream and delivers the decoded string value, then one status transaction.
// ----------------------------------------------------------------------------
//
//   channel   prefix  direction  transaction
//   -------   ------  ---------  ---------------------------------------------
//   request   req_    in         one document byte plus end-of-text flag
//   response  rsp_    out        one decoded value character, or final status
//   config    csr_    in/out     APB-style 64-bit register access
//
// A byte is taken every cycle unless the request side stalls. It is held in the
// input register, processed by the scanner logic, and its results (at most two:
// a character and the status at end of text) enter a four-entry output queue,
// from whose head they are offered on the response channel. The input register
// advances only while the queue holds at most two results, so the request side
// stalls once three results wait unread. Reset is synchronous and active high;
// it restores the scanner, the input valid flag, the queue pointers and the
// configuration registers to their reset values.
//
module json_string_member_extract_unit (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_value_char,
   output logic        rsp_is_final,
   output logic [1:0]  rsp_status,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

`include "json_string_member_extract_unit_assert.svh"

   localparam int PTR_W = $clog2(jsme_pkg::OUT_DEPTH);
   localparam int CNT_W = $clog2(jsme_pkg::OUT_DEPTH + 1);

   // -------------------------------------------------------------------------
   // Configuration registers. Writes land on the access phase; the whole
   // register is written, unused data bits are dropped.
   // -------------------------------------------------------------------------
   logic [5:0]                              key_length_ff;
   logic [jsme_pkg::KEY_REGS-1:0][63:0]     key_ff;
   logic [7:0]                              max_chars_ff;
   logic                                    csr_write;
   jsme_pkg::reg_index_type                 csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = jsme_pkg::reg_index_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= 6'd1;
         key_ff        <= '0;
         max_chars_ff  <= 8'hFF;
      end else if (csr_write) begin
         case (csr_index)
            jsme_pkg::REG_KEY_LENGTH: begin
               key_length_ff <= csr_pwdata[5:0];
            end
            jsme_pkg::REG_KEY_0_7: begin
               key_ff[0] <= csr_pwdata;
            end
            jsme_pkg::REG_KEY_8_15: begin
               key_ff[1] <= csr_pwdata;
            end
            jsme_pkg::REG_KEY_16_23: begin
               key_ff[2] <= csr_pwdata;
            end
            jsme_pkg::REG_KEY_24_31: begin
               key_ff[3] <= csr_pwdata;
            end
            jsme_pkg::REG_MAX_CHARS: begin
               max_chars_ff <= csr_pwdata[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         jsme_pkg::REG_KEY_LENGTH: csr_prdata = {58'd0, key_length_ff};
         jsme_pkg::REG_KEY_0_7:    csr_prdata = key_ff[0];
         jsme_pkg::REG_KEY_8_15:   csr_prdata = key_ff[1];
         jsme_pkg::REG_KEY_16_23:  csr_prdata = key_ff[2];
         jsme_pkg::REG_KEY_24_31:  csr_prdata = key_ff[3];
         jsme_pkg::REG_MAX_CHARS:  csr_prdata = {56'd0, max_chars_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // A key length of zero behaves as one; lengths past the key storage clamp.
   logic [5:0] eff_len;
   always_comb begin
      if (key_length_ff == 6'd0) begin
         eff_len = 6'd1;
      end else if (key_length_ff > 6'(jsme_pkg::MAX_KEY_BYTES)) begin
         eff_len = 6'(jsme_pkg::MAX_KEY_BYTES);
      end else begin
         eff_len = key_length_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Input register.
   // -------------------------------------------------------------------------
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;
   logic       req_accept;

   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_end_of_text;
      end
   end

   // -------------------------------------------------------------------------
   // Scanner state.
   // -------------------------------------------------------------------------
   jsme_pkg::phase_type phase_ff, phase_in;
   logic [5:0]          pos_ff, pos_in;
   logic                space_ff, space_in;
   logic [2:0]          hex_ff, hex_in;
   logic [7:0]          count_ff, count_in;
   logic                sent_ff, sent_in;

   // Compare one byte against the key at a given position. A quote that does
   // not match still opens a fresh candidate key.
   function automatic jsme_pkg::cand_type cand(input logic [7:0] b,
                                               input logic [5:0] pos,
                                               input logic [5:0] len,
                                               input logic [255:0] keys);
      jsme_pkg::cand_type r;
      logic [7:0]         kb;
      kb = (pos < 6'(jsme_pkg::MAX_KEY_BYTES)) ? keys[{pos[4:0], 3'b000} +: 8] : 8'd0;
      if ((pos < len) && (b == kb)) begin
         r.phase = jsme_pkg::PH_MATCH;
         r.pos   = pos + 6'd1;
      end else if (b == jsme_pkg::CH_QUOTE) begin
         r.phase = jsme_pkg::PH_MATCH;
         r.pos   = 6'd0;
      end else begin
         r.phase = jsme_pkg::PH_SEARCH;
         r.pos   = 6'd0;
      end
      return r;
   endfunction

   logic               chr_v;
   logic [7:0]         chr_val;
   logic [7:0]         esc_val;
   logic               st_v;
   logic [1:0]         st_val;
   jsme_pkg::cand_type cres;
   logic [5:0]         cand_pos;

   // The candidate compare always starts at position zero after a key's
   // closing quote, and otherwise continues the running match.
   assign cand_pos = (phase_ff == jsme_pkg::PH_AFTERKEY) ? 6'd0 : pos_ff;
   assign cres     = cand(in_byte_ff, cand_pos, eff_len, key_ff);

   always_comb begin
      case (in_byte_ff)
         jsme_pkg::CH_LOW_N: esc_val = jsme_pkg::CH_LF;
         jsme_pkg::CH_LOW_R: esc_val = jsme_pkg::CH_CR;
         jsme_pkg::CH_LOW_T: esc_val = jsme_pkg::CH_TAB;
         jsme_pkg::CH_LOW_B: esc_val = jsme_pkg::CH_BS;
         jsme_pkg::CH_LOW_F: esc_val = jsme_pkg::CH_FF;
         jsme_pkg::CH_LOW_U: esc_val = jsme_pkg::CH_QUESTION;
         default:            esc_val = in_byte_ff;
      endcase
   end

   // Next state and results of the byte in the input register.
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      space_in = space_ff;
      hex_in   = hex_ff;
      count_in = count_ff;
      sent_in  = sent_ff;
      chr_v    = 1'b0;
      chr_val  = in_byte_ff;
      st_v     = 1'b0;
      st_val   = jsme_pkg::ST_FOUND;

      if (!sent_ff) begin
         case (phase_ff)
            jsme_pkg::PH_MATCH: begin
               if (pos_ff >= eff_len) begin
                  pos_in   = 6'd0;
                  if (in_byte_ff == jsme_pkg::CH_QUOTE) begin
                     phase_in = jsme_pkg::PH_AFTERKEY;
                     space_in = 1'b0;
                  end else begin
                     phase_in = jsme_pkg::PH_SEARCH;
                  end
               end else begin
                  phase_in = cres.phase;
                  pos_in   = cres.pos;
               end
            end
            jsme_pkg::PH_AFTERKEY: begin
               if (jsme_pkg::is_ws(in_byte_ff)) begin
                  space_in = 1'b1;
               end else if (in_byte_ff == jsme_pkg::CH_COLON) begin
                  phase_in = jsme_pkg::PH_AFTERCOLON;
               end else if (!space_ff) begin
                  phase_in = cres.phase;
                  pos_in   = cres.pos;
               end else begin
                  phase_in = (in_byte_ff == jsme_pkg::CH_QUOTE) ? jsme_pkg::PH_MATCH
                                                                : jsme_pkg::PH_SEARCH;
                  pos_in   = 6'd0;
               end
            end
            jsme_pkg::PH_AFTERCOLON: begin
               if (in_byte_ff == jsme_pkg::CH_QUOTE) begin
                  phase_in = jsme_pkg::PH_VALUE;
                  count_in = 8'd0;
               end else if (!jsme_pkg::is_ws(in_byte_ff)) begin
                  st_v    = 1'b1;
                  st_val  = jsme_pkg::ST_NOT_STRING;
                  sent_in = 1'b1;
               end
            end
            jsme_pkg::PH_VALUE: begin
               if (in_byte_ff == jsme_pkg::CH_QUOTE) begin
                  st_v    = 1'b1;
                  st_val  = (count_ff != 8'd0) ? jsme_pkg::ST_FOUND : jsme_pkg::ST_EMPTY;
                  sent_in = 1'b1;
               end else if ((in_byte_ff == jsme_pkg::CH_BACKSLASH) && !in_last_ff) begin
                  phase_in = jsme_pkg::PH_ESCAPE;
               end else if (count_ff < max_chars_ff) begin
                  chr_v    = 1'b1;
                  count_in = count_ff + 8'd1;
               end
            end
            jsme_pkg::PH_ESCAPE: begin
               chr_val  = esc_val;
               phase_in = jsme_pkg::PH_VALUE;
               if (in_byte_ff == jsme_pkg::CH_LOW_U) begin
                  hex_in   = 3'd4;
                  phase_in = jsme_pkg::PH_HEXSKIP;
               end
               if (count_ff < max_chars_ff) begin
                  chr_v    = 1'b1;
                  count_in = count_ff + 8'd1;
               end
            end
            jsme_pkg::PH_HEXSKIP: begin
               hex_in = hex_ff - 3'd1;
               if (hex_ff == 3'd1) begin
                  phase_in = jsme_pkg::PH_VALUE;
               end
            end
            default: begin
               pos_in   = 6'd0;
               phase_in = (in_byte_ff == jsme_pkg::CH_QUOTE) ? jsme_pkg::PH_MATCH
                                                             : jsme_pkg::PH_SEARCH;
            end
         endcase
      end

      // End of text: status from where the scan stopped, then a clean start.
      if (in_last_ff) begin
         if (!sent_in) begin
            st_v = 1'b1;
            if ((phase_in == jsme_pkg::PH_VALUE) || (phase_in == jsme_pkg::PH_ESCAPE) ||
                (phase_in == jsme_pkg::PH_HEXSKIP)) begin
               st_val = (count_in != 8'd0) ? jsme_pkg::ST_FOUND : jsme_pkg::ST_EMPTY;
            end else if (phase_in == jsme_pkg::PH_AFTERCOLON) begin
               st_val = jsme_pkg::ST_NOT_STRING;
            end else begin
               st_val = jsme_pkg::ST_MISSING;
            end
         end
         phase_in = jsme_pkg::PH_SEARCH;
         pos_in   = 6'd0;
         space_in = 1'b0;
         hex_in   = 3'd0;
         count_in = 8'd0;
         sent_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsme_pkg::PH_SEARCH;
         pos_ff   <= 6'd0;
         space_ff <= 1'b0;
         hex_ff   <= 3'd0;
         count_ff <= 8'd0;
         sent_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         space_ff <= space_in;
         hex_ff   <= hex_in;
         count_ff <= count_in;
         sent_ff  <= sent_in;
      end
   end

   // -------------------------------------------------------------------------
   // Output queue. A character always precedes the status of the same byte.
   // -------------------------------------------------------------------------
   jsme_pkg::rsp_type              fifo_ff [jsme_pkg::OUT_DEPTH];
   logic [PTR_W-1:0]               wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]               fill_ff, fill_in;
   logic [1:0]                     push_n;
   logic                           pop;
   jsme_pkg::rsp_type              slot0, slot1;
   jsme_pkg::rsp_type              chr_rsp, st_rsp, head;

   assign advance = in_valid_ff && (fill_ff <= CNT_W'(jsme_pkg::OUT_DEPTH - 2));

   assign chr_rsp = '{value_char: chr_val, is_final: 1'b0, status: jsme_pkg::ST_FOUND};
   assign st_rsp  = '{value_char: 8'd0, is_final: 1'b1, status: st_val};
   assign slot0   = chr_v ? chr_rsp : st_rsp;
   assign slot1   = st_rsp;
   assign push_n  = advance ? ({1'b0, chr_v} + {1'b0, st_v}) : 2'd0;

   assign head      = fifo_ff[rd_ptr_ff];
   assign rsp_valid = (fill_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_value_char = head.value_char;
   assign rsp_is_final   = head.is_final;
   assign rsp_status     = head.status;

   assign fill_in = fill_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_n);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= slot0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= slot1;
      end
   end

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   `JSME_ASSERT_NOW(a_queue_room, clock, reset, push_n != 2'd0,
      fill_ff <= CNT_W'(jsme_pkg::OUT_DEPTH - 2), "result queue written without room")
   `JSME_ASSERT_NEXT(a_doc_end_clears, clock, reset, advance && in_last_ff,
      phase_ff == jsme_pkg::PH_SEARCH && count_ff == 8'd0 && !sent_ff,
      "scanner state not cleared after end of text")
   `JSME_ASSERT_NOW(a_quiet_after_status, clock, reset, advance && sent_ff,
      push_n == 2'd0, "result produced after the status of this document")
   `JSME_ASSERT_NOW(a_count_bound, clock, reset, advance && chr_v,
      count_ff < max_chars_ff, "character delivered beyond the configured limit")

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// JSON string member extract unit testbench
// Streams JSON-like documents through the extract unit byte by byte under
// several key and length settings, predicts every decoded value character and
// final status with a cycle-free scanner model, and checks each response
// transaction in order while both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // The run is bounded far above the slowest legal run of about 1300 bytes,
   // each with the longest sender gap and two results behind the longest stalls.
   localparam int CYCLE_LIMIT   = 500000;
   // A byte passes the input register and the output queue inside the unit;
   // this pause lets it drain before a register is touched or the run ends.
   localparam int SETTLE_CYCLES = 8;
   // Bytes of random documents generated under each key setting.
   localparam int PHASE_BYTES   = 160;
   // Mismatch lines printed before the report goes quiet and only counts.
   localparam int REPORT_LINES  = 40;

   // Kinds of documents the generator produces.
   typedef enum int {
      DOC_NOISE,
      DOC_MISSING,
      DOC_BROKEN,
      DOC_NOT_STRING,
      DOC_CUT,
      DOC_FOUND
   } doc_kind_type;

   // One byte of a document as the request channel carries it.
   typedef struct {
      logic [7:0] text;
      logic       at_end;
   } doc_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = 8'h00;
   logic        req_end_of_text = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_value_char;
   logic        rsp_is_final;
   logic [1:0]  rsp_status;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = 6'd0;
   logic [63:0] csr_pwdata = 64'd0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   json_string_member_extract_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value_char  (rsp_value_char),
      .rsp_is_final    (rsp_is_final),
      .rsp_status      (rsp_status),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // -------------------------------------------------------------------------
   // Scanner model. The copies of the registers start at their reset values
   // and are updated by every register write, which only happens while the
   // unit is idle.
   // -------------------------------------------------------------------------
   logic [5:0]  key_len_cfg = 6'd1;
   logic [63:0] key_words [4] = '{64'd0, 64'd0, 64'd0, 64'd0};
   logic [7:0]  max_chars_cfg = 8'd255;

   jsme_pkg::phase_type scan_phase = jsme_pkg::PH_SEARCH;
   logic [5:0]  match_pos = 6'd0;
   logic        blank_after_key = 1'b0;
   logic [2:0]  hex_left = 3'd0;
   logic [7:0]  value_chars = 8'd0;
   logic        status_given = 1'b0;

   // Decoded characters and statuses that the unit still owes, oldest first.
   jsme_pkg::rsp_type value_results_due [$];

   // The effective key length clamps the register value to 1..MAX_KEY_BYTES.
   function automatic logic [5:0] active_key_length();
      if (key_len_cfg == 6'd0) return 6'd1;
      if (key_len_cfg > jsme_pkg::MAX_KEY_BYTES) return 6'(jsme_pkg::MAX_KEY_BYTES);
      return key_len_cfg;
   endfunction

   function automatic logic [7:0] key_char(input logic [5:0] k);
      if (k >= 6'd32) return 8'h00;
      return key_words[k[4:3]][k[2:0] * 8 +: 8];
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return b == jsme_pkg::CH_SPACE || b == jsme_pkg::CH_TAB ||
             b == jsme_pkg::CH_CR || b == jsme_pkg::CH_LF;
   endfunction

   // Compares one byte against the key at the current match position. A
   // mismatching quote starts a fresh candidate.
   function automatic void try_key_byte(input logic [7:0] b);
      if (match_pos < active_key_length() && b == key_char(match_pos)) begin
         scan_phase = jsme_pkg::PH_MATCH;
         match_pos  = match_pos + 6'd1;
      end else if (b == jsme_pkg::CH_QUOTE) begin
         scan_phase = jsme_pkg::PH_MATCH;
         match_pos  = 6'd0;
      end else begin
         scan_phase = jsme_pkg::PH_SEARCH;
         match_pos  = 6'd0;
      end
   endfunction

   // A character is delivered only while the output capacity allows it.
   function automatic void post_char(input logic [7:0] c);
      jsme_pkg::rsp_type r;
      if (value_chars < max_chars_cfg) begin
         r.value_char = c;
         r.is_final   = 1'b0;
         r.status     = jsme_pkg::ST_FOUND;
         value_results_due.push_back(r);
         value_chars = value_chars + 8'd1;
      end
   endfunction

   function automatic void post_status(input logic [1:0] st);
      jsme_pkg::rsp_type r;
      r.value_char = 8'h00;
      r.is_final   = 1'b1;
      r.status     = st;
      value_results_due.push_back(r);
      status_given = 1'b1;
   endfunction

   // Advances the scanner by one accepted byte and queues what it delivers.
   function automatic void scan_json_byte(input logic [7:0] b, input logic at_end);
      logic [7:0] c;
      if (!status_given) begin
         case (scan_phase)
            jsme_pkg::PH_MATCH: begin
               if (match_pos >= active_key_length()) begin
                  // The whole key has matched; only its closing quote counts.
                  if (b == jsme_pkg::CH_QUOTE) begin
                     scan_phase      = jsme_pkg::PH_AFTERKEY;
                     blank_after_key = 1'b0;
                  end else begin
                     scan_phase = jsme_pkg::PH_SEARCH;
                  end
                  match_pos = 6'd0;
               end else begin
                  try_key_byte(b);
               end
            end
            jsme_pkg::PH_AFTERKEY: begin
               if (is_blank(b)) begin
                  blank_after_key = 1'b1;
               end else if (b == jsme_pkg::CH_COLON) begin
                  scan_phase = jsme_pkg::PH_AFTERCOLON;
               end else if (!blank_after_key) begin
                  // The closing quote doubles as the opening of a candidate.
                  match_pos = 6'd0;
                  try_key_byte(b);
               end else begin
                  if (b == jsme_pkg::CH_QUOTE) scan_phase = jsme_pkg::PH_MATCH;
                  else scan_phase = jsme_pkg::PH_SEARCH;
                  match_pos = 6'd0;
               end
            end
            jsme_pkg::PH_AFTERCOLON: begin
               if (b == jsme_pkg::CH_QUOTE) begin
                  scan_phase  = jsme_pkg::PH_VALUE;
                  value_chars = 8'd0;
               end else if (!is_blank(b)) begin
                  post_status(jsme_pkg::ST_NOT_STRING);
               end
            end
            jsme_pkg::PH_VALUE: begin
               if (b == jsme_pkg::CH_QUOTE) begin
                  if (value_chars > 8'd0) post_status(jsme_pkg::ST_FOUND);
                  else post_status(jsme_pkg::ST_EMPTY);
               end else if (b == jsme_pkg::CH_BACKSLASH && !at_end) begin
                  scan_phase = jsme_pkg::PH_ESCAPE;
               end else begin
                  post_char(b);
               end
            end
            jsme_pkg::PH_ESCAPE: begin
               scan_phase = jsme_pkg::PH_VALUE;
               case (b)
                  jsme_pkg::CH_LOW_N: c = jsme_pkg::CH_LF;
                  jsme_pkg::CH_LOW_R: c = jsme_pkg::CH_CR;
                  jsme_pkg::CH_LOW_T: c = jsme_pkg::CH_TAB;
                  jsme_pkg::CH_LOW_B: c = jsme_pkg::CH_BS;
                  jsme_pkg::CH_LOW_F: c = jsme_pkg::CH_FF;
                  jsme_pkg::CH_LOW_U: begin
                     c          = jsme_pkg::CH_QUESTION;
                     hex_left   = 3'd4;
                     scan_phase = jsme_pkg::PH_HEXSKIP;
                  end
                  default: c = b;
               endcase
               post_char(c);
            end
            jsme_pkg::PH_HEXSKIP: begin
               hex_left = hex_left - 3'd1;
               if (hex_left == 3'd0) scan_phase = jsme_pkg::PH_VALUE;
            end
            default: begin
               scan_phase = jsme_pkg::PH_SEARCH;
               if (b == jsme_pkg::CH_QUOTE) begin
                  scan_phase = jsme_pkg::PH_MATCH;
                  match_pos  = 6'd0;
               end
            end
         endcase
      end
      if (at_end) begin
         if (!status_given) begin
            if (scan_phase == jsme_pkg::PH_VALUE || scan_phase == jsme_pkg::PH_ESCAPE ||
                scan_phase == jsme_pkg::PH_HEXSKIP) begin
               if (value_chars > 8'd0) post_status(jsme_pkg::ST_FOUND);
               else post_status(jsme_pkg::ST_EMPTY);
            end else if (scan_phase == jsme_pkg::PH_AFTERCOLON) begin
               post_status(jsme_pkg::ST_NOT_STRING);
            end else begin
               post_status(jsme_pkg::ST_MISSING);
            end
         end
         // Every document starts from a clean scanner.
         scan_phase      = jsme_pkg::PH_SEARCH;
         match_pos       = 6'd0;
         blank_after_key = 1'b0;
         hex_left        = 3'd0;
         value_chars     = 8'd0;
         status_given    = 1'b0;
      end
   endfunction

   // -------------------------------------------------------------------------
   // Mismatch reporting and idle timing.
   // -------------------------------------------------------------------------
   int mismatches = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= REPORT_LINES)
         $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // Each side draws a random idle wait for each transaction, except during calm
   // stretches in which it never idles.
   function automatic int pick_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) calm = $urandom_range(15, 60);
      return $urandom_range(0, 12);
   endfunction

   // -------------------------------------------------------------------------
   // Request driver. It pulls bytes from the send queue, holds each one on the
   // channel until its transaction completes, and feeds every completed
   // transaction to the scanner model.
   // -------------------------------------------------------------------------
   doc_byte_type text_to_send [$];
   doc_byte_type next_byte;
   int           send_wait = 0;
   int           send_calm = 0;
   int           bytes_taken = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            scan_json_byte(req_text_byte, req_end_of_text);
            bytes_taken++;
         end
         // A byte still waiting for ready stays on the channel untouched.
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (text_to_send.size() > 0) begin
               next_byte = text_to_send.pop_front();
               req_valid       <= 1'b1;
               req_text_byte   <= next_byte.text;
               req_end_of_text <= next_byte.at_end;
               send_wait = pick_wait(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor. Every completed response transaction is compared field
   // by field with the oldest owed result. Ready drops for a drawn number of
   // cycles after each transaction; the count runs down while a response is
   // offered, so the stall always lands on a real result.
   // -------------------------------------------------------------------------
   int take_wait = 0;
   int take_calm = 0;
   int chars_checked = 0;
   int status_counts [4] = '{0, 0, 0, 0};

   task automatic check_response();
      jsme_pkg::rsp_type want;
      if (value_results_due.size() == 0) begin
         report_mismatch("response with nothing owed",
                         64'({rsp_value_char, rsp_is_final, rsp_status}), 64'd0);
         return;
      end
      want = value_results_due.pop_front();
      if (rsp_value_char !== want.value_char)
         report_mismatch("value_char", 64'(rsp_value_char), 64'(want.value_char));
      if (rsp_is_final !== want.is_final)
         report_mismatch("is_final", 64'(rsp_is_final), 64'(want.is_final));
      if (rsp_status !== want.status)
         report_mismatch("status", 64'(rsp_status), 64'(want.status));
      if (want.is_final) status_counts[want.status]++;
      else chars_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_response();
            take_wait = pick_wait(take_calm);
         end else if (rsp_valid && take_wait > 0) begin
            take_wait--;
         end
         rsp_ready <= (take_wait == 0);
      end
   end

   // The cycle counter ends a hung run.
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d bytes queued and %0d results owed.",
                  cycle_count, text_to_send.size(), value_results_due.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Register access. Each write is read back; a write completes at the edge
   // where psel, penable, pwrite and pready are high, and the read setup
   // follows at once.
   // -------------------------------------------------------------------------
   int key_settings = 0;

   task automatic write_register(input jsme_pkg::reg_index_type idx,
                                 input logic [63:0] value);
      logic [63:0] held;
      logic [63:0] got;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      held = value;
      case (idx)
         jsme_pkg::REG_KEY_LENGTH: begin
            key_len_cfg = value[5:0];
            held = {58'd0, value[5:0]};
         end
         jsme_pkg::REG_KEY_0_7:   key_words[0] = value;
         jsme_pkg::REG_KEY_8_15:  key_words[1] = value;
         jsme_pkg::REG_KEY_16_23: key_words[2] = value;
         jsme_pkg::REG_KEY_24_31: key_words[3] = value;
         jsme_pkg::REG_MAX_CHARS: begin
            max_chars_cfg = value[7:0];
            held = {56'd0, value[7:0]};
         end
         default: ;
      endcase
      if (got !== held) report_mismatch("register readback", got, held);
   endtask

   function automatic logic [7:0] letter();
      return 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   // Programs a fresh key of the given length register value and the given
   // character limit. Key bytes in use are letters unless spelled out; bytes
   // past the key are random so every register bit gets exercised.
   task automatic load_key(input int len_value, input int max_value, input string spelled);
      jsme_pkg::reg_index_type key_regs [4];
      logic [7:0]    key_text [32];
      logic [63:0]   word;
      int            span;
      key_regs = '{jsme_pkg::REG_KEY_0_7, jsme_pkg::REG_KEY_8_15,
                   jsme_pkg::REG_KEY_16_23, jsme_pkg::REG_KEY_24_31};
      span = len_value < 1 ? 1 : (len_value > jsme_pkg::MAX_KEY_BYTES ?
                                  jsme_pkg::MAX_KEY_BYTES : len_value);
      for (int i = 0; i < 32; i++) key_text[i] = (i < span) ? letter() : 8'($urandom);
      for (int i = 0; i < spelled.len(); i++) key_text[i] = spelled[i];
      write_register(jsme_pkg::REG_KEY_LENGTH, 64'(len_value));
      for (int w = 0; w < 4; w++) begin
         for (int i = 0; i < 8; i++) word[i * 8 +: 8] = key_text[w * 8 + i];
         write_register(key_regs[w], word);
      end
      write_register(jsme_pkg::REG_MAX_CHARS, 64'(max_value));
      key_settings++;
   endtask

   // -------------------------------------------------------------------------
   // Document generation. A document is built in doc_text and then moved to
   // the send queue with the end-of-text flag on its last byte.
   // -------------------------------------------------------------------------
   logic [7:0] doc_text [$];
   int         docs_queued = 0;
   string      hex_digits = "0123456789abcdefABCDEF";

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) doc_text.push_back(s[i]);
   endtask

   task automatic finish_doc();
      doc_byte_type item;
      foreach (doc_text[i]) begin
         item.text   = doc_text[i];
         item.at_end = (i == doc_text.size() - 1);
         text_to_send.push_back(item);
      end
      docs_queued++;
      doc_text.delete();
   endtask

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 3))
         0: return jsme_pkg::CH_SPACE;
         1: return jsme_pkg::CH_TAB;
         2: return jsme_pkg::CH_CR;
         default: return jsme_pkg::CH_LF;
      endcase
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(32, 126));
      while (c == jsme_pkg::CH_QUOTE || c == jsme_pkg::CH_BACKSLASH);
      return c;
   endfunction

   task automatic put_blanks(input int most);
      repeat ($urandom_range(0, most)) doc_text.push_back(blank_byte());
   endtask

   task automatic put_key();
      doc_text.push_back(jsme_pkg::CH_QUOTE);
      for (int i = 0; i < active_key_length(); i++) doc_text.push_back(key_char(6'(i)));
      doc_text.push_back(jsme_pkg::CH_QUOTE);
   endtask

   // A string value with plain text, raw control and high bytes, and escapes.
   task automatic put_string_value(input bit closed);
      int n;
      int r;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6);
      doc_text.push_back(jsme_pkg::CH_QUOTE);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            doc_text.push_back(plain_char());
         end else if (r < 75) begin
            if ($urandom_range(0, 1)) doc_text.push_back(8'($urandom_range(128, 255)));
            else doc_text.push_back(8'($urandom_range(0, 31)));
         end else begin
            doc_text.push_back(jsme_pkg::CH_BACKSLASH);
            case ($urandom_range(0, 9))
               0: doc_text.push_back(jsme_pkg::CH_LOW_N);
               1: doc_text.push_back(jsme_pkg::CH_LOW_R);
               2: doc_text.push_back(jsme_pkg::CH_LOW_T);
               3: doc_text.push_back(jsme_pkg::CH_LOW_B);
               4: doc_text.push_back(jsme_pkg::CH_LOW_F);
               5: doc_text.push_back(jsme_pkg::CH_QUOTE);
               6: doc_text.push_back(jsme_pkg::CH_BACKSLASH);
               7: doc_text.push_back(plain_char());
               default: begin
                  // The four bytes after a unicode escape are dropped whatever
                  // they are, quotes and backslashes included.
                  doc_text.push_back(jsme_pkg::CH_LOW_U);
                  repeat (4) begin
                     case ($urandom_range(0, 5))
                        0: doc_text.push_back(jsme_pkg::CH_QUOTE);
                        1: doc_text.push_back(8'($urandom));
                        default: doc_text.push_back(hex_digits[$urandom_range(0, 21)]);
                     endcase
                  end
               end
            endcase
         end
      end
      if (closed) doc_text.push_back(jsme_pkg::CH_QUOTE);
   endtask

   // Another member whose key is unrelated, a cut-off key prefix, or the key
   // with an extra byte.
   task automatic put_decoy();
      int n;
      int cut;
      n = active_key_length();
      doc_text.push_back(jsme_pkg::CH_QUOTE);
      case ($urandom_range(0, 2))
         0: repeat ($urandom_range(1, 4)) doc_text.push_back(letter());
         1: begin
            cut = $urandom_range(0, n - 1);
            for (int i = 0; i < cut; i++) doc_text.push_back(key_char(6'(i)));
            doc_text.push_back(letter());
         end
         default: begin
            for (int i = 0; i < n; i++) doc_text.push_back(key_char(6'(i)));
            doc_text.push_back(letter());
         end
      endcase
      doc_text.push_back(jsme_pkg::CH_QUOTE);
      put_blanks(1);
      doc_text.push_back(jsme_pkg::CH_COLON);
      put_blanks(1);
      put_string_value(1'b1);
      doc_text.push_back(",");
   endtask

   // A key that lacks its closing quote or is followed by something other than
   // the usual colon, so the scanner must restart its search from the right byte.
   task automatic put_broken_key();
      case ($urandom_range(0, 4))
         0: begin
            put_key();
            doc_text.push_back(letter());
         end
         1: begin
            put_key();
            doc_text.push_back(blank_byte());
            doc_text.push_back(letter());
         end
         2: begin
            put_key();
            put_key();
         end
         3: begin
            put_key();
            doc_text.push_back(blank_byte());
            put_key();
         end
         default: begin
            doc_text.push_back(jsme_pkg::CH_QUOTE);
            for (int i = 0; i < active_key_length(); i++)
               doc_text.push_back(key_char(6'(i)));
         end
      endcase
   endtask

   function automatic doc_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return DOC_NOISE;
      if (r < 18) return DOC_MISSING;
      if (r < 35) return DOC_BROKEN;
      if (r < 45) return DOC_NOT_STRING;
      if (r < 60) return DOC_CUT;
      return DOC_FOUND;
   endfunction

   task automatic put_document();
      doc_kind_type kind;
      int           cut;
      kind = pick_kind();
      if (kind == DOC_NOISE) begin
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 3) == 0) doc_text.push_back(jsme_pkg::CH_QUOTE);
            else doc_text.push_back(8'($urandom));
         end
      end else if (kind == DOC_MISSING) begin
         doc_text.push_back("{");
         repeat ($urandom_range(1, 3)) put_decoy();
         doc_text.push_back("}");
      end else begin
         if ($urandom_range(0, 1)) doc_text.push_back("{");
         put_blanks(2);
         repeat ($urandom_range(0, 2)) begin
            put_decoy();
            put_blanks(1);
         end
         if (kind == DOC_BROKEN) put_broken_key();
         else put_key();
         put_blanks(2);
         doc_text.push_back(jsme_pkg::CH_COLON);
         put_blanks(2);
         if (kind == DOC_NOT_STRING) begin
            case ($urandom_range(0, 4))
               0: doc_text.push_back(8'($urandom_range(8'h30, 8'h39)));
               1: doc_text.push_back(jsme_pkg::CH_LOW_T);
               2: doc_text.push_back("{");
               3: doc_text.push_back("[");
               default: doc_text.push_back("-");
            endcase
            repeat ($urandom_range(0, 3)) doc_text.push_back(plain_char());
         end else begin
            put_string_value(1'b1);
         end
         // Bytes after the value, sometimes a second copy of the member,
         // must not produce anything.
         case ($urandom_range(0, 3))
            0: ;
            1: doc_text.push_back("}");
            2: begin
               doc_text.push_back(",");
               put_key();
               doc_text.push_back(jsme_pkg::CH_COLON);
               put_string_value(1'b1);
               doc_text.push_back("}");
            end
            default: begin
               doc_text.push_back(",");
               put_decoy();
            end
         endcase
         // A cut document ends anywhere: in the key, after the colon, inside
         // the value, on a backslash or among the skipped unicode digits.
         if (kind == DOC_CUT) begin
            cut = $urandom_range(1, doc_text.size());
            doc_text = doc_text[0:cut - 1];
         end
      end
      finish_doc();
   endtask

   // Waits until every queued byte has been taken and every owed result has
   // arrived, then lets the last bytes that cause no result drain out.
   task automatic wait_idle();
      while (text_to_send.size() > 0 || req_valid || value_results_due.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_documents(input int byte_goal);
      int goal;
      goal = text_to_send.size() + byte_goal;
      while (text_to_send.size() < goal) put_document();
      wait_idle();
   endtask

   // -------------------------------------------------------------------------
   // Test sequence.
   // -------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed documents with the one-letter key k: an empty value, a value
      // that is not a string, a backslash as the very last byte, the lowest
      // and highest bytes alone, and a unicode escape that swallows the
      // closing quote and is cut short by the end of the text.
      load_key(1, 255, "k");
      add_text("\"k\":\"\"");
      finish_doc();
      add_text("\"k\":1");
      finish_doc();
      add_text("\"k\":\"\\");
      finish_doc();
      doc_text.push_back(8'h00);
      finish_doc();
      doc_text.push_back(8'hFF);
      finish_doc();
      add_text("\"k\":\"\\u\"");
      finish_doc();
      wait_idle();

      // Random documents under shortest, longest and out-of-range key lengths,
      // zero, small and full output capacity, and a key with a quote inside.
      load_key(1, 255, "");
      run_documents(PHASE_BYTES);
      load_key(32, 255, "");
      run_documents(PHASE_BYTES);
      load_key(0, 255, "");
      run_documents(PHASE_BYTES);
      load_key(63, 0, "");
      run_documents(PHASE_BYTES);
      load_key($urandom_range(2, 31), $urandom_range(1, 6), "");
      run_documents(PHASE_BYTES);
      load_key(3, 255, "a\"b");
      run_documents(PHASE_BYTES);
      load_key($urandom_range(2, 12), 255, "");
      run_documents(PHASE_BYTES);
      load_key($urandom_range(1, 8), $urandom_range(0, 255), "");
      run_documents(PHASE_BYTES);

      $display("Streamed %0d documents (%0d bytes) under %0d key settings.",
               docs_queued, bytes_taken, key_settings);
      $display("Checked %0d value characters; found/empty/missing/not-string: %0d/%0d/%0d/%0d.",
               chars_checked, status_counts[jsme_pkg::ST_FOUND],
               status_counts[jsme_pkg::ST_EMPTY], status_counts[jsme_pkg::ST_MISSING],
               status_counts[jsme_pkg::ST_NOT_STRING]);
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/jsme_pkg.sv
rtl/json_string_member_extract_unit.sv
bench/testbench.sv
